[sv/chim_pkg.sv]
package chim_pkg;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  // back-end walk states
  typedef enum logic [2:0] {
    BE_IDLE,
    BE_HEAD_RD,
    BE_HEAD_CHK,
    BE_POOL_RD,
    BE_POOL_CHK,
    BE_RESULT
  } be_state_t;

  // front-end divider states
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

endpackage

[sv/chim_front.sv]
module chim_front import chim_pkg::*; #(
  parameter int BUCKETS  = 128,
  parameter int KEY_BITS = 22,
  parameter int VALUE_BITS = 8,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            bucket_count,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [KEY_BITS-1:0]   in_task_id,
  input  logic [VALUE_BITS-1:0] in_index,
  output logic                  q_valid,
  input  logic                  q_full,
  output logic [1:0]            q_func,
  output logic [KEY_BITS-1:0]   q_key,
  output logic [VALUE_BITS-1:0] q_value,
  output logic [BW-1:0]         q_bucket
);

  localparam int MW = (BW + 1 > 8) ? BW + 1 : 8;
  localparam int CW = $clog2(KEY_BITS + 1);

  fe_state_t              state_r, state_nxt;
  logic [1:0]             func_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic [KEY_BITS-1:0]    quo_r;
  logic [MW:0]            rem_r, rem_nxt;
  logic [MW-1:0]          mod_r, mod_c;
  logic [CW-1:0]          cnt_r;
  logic [MW:0]            trial;

  // modulus: zero maps to one, saturate at BUCKETS
  always_comb begin
    if (bucket_count == 8'd0) mod_c = MW'(1);
    else if (MW'(bucket_count) > MW'(BUCKETS)) mod_c = MW'(BUCKETS);
    else mod_c = MW'(bucket_count);
  end

  // one restoring divide step per cycle
  always_comb begin
    trial = {rem_r[MW-1:0], quo_r[KEY_BITS-1]};
    if (trial >= {1'b0, mod_r}) rem_nxt = trial - {1'b0, mod_r};
    else rem_nxt = trial;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    q_valid   = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = FE_DIV;
      end
      FE_DIV: begin
        if (cnt_r == CW'(KEY_BITS - 1)) state_nxt = FE_PUSH;
      end
      FE_PUSH: begin
        q_valid = 1'b1;
        if (!q_full) state_nxt = FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FE_IDLE;
    else state_r <= state_nxt;
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state_r == FE_IDLE && in_valid) begin
      func_r <= in_func;
      key_r  <= in_task_id;
      val_r  <= in_index;
      quo_r  <= in_task_id;
      rem_r  <= '0;
      mod_r  <= mod_c;
      cnt_r  <= '0;
    end else if (state_r == FE_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[KEY_BITS-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign q_func   = func_r;
  assign q_key    = key_r;
  assign q_value  = val_r;
  assign q_bucket = rem_r[BW-1:0];

endmodule

[sv/chim_queue.sv]
module chim_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign rd_data = mem_r[rp_r];

  // two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

[sv/chim_back.sv]
module chim_back import chim_pkg::*; #(
  parameter int BUCKETS    = 128,
  parameter int POOL_DEPTH = 128,
  parameter int KEY_BITS   = 22,
  parameter int VALUE_BITS = 8,
  localparam int BW = $clog2(BUCKETS),
  localparam int PW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [1:0]            q_func,
  input  logic [KEY_BITS-1:0]   q_key,
  input  logic [VALUE_BITS-1:0] q_value,
  input  logic [BW-1:0]         q_bucket,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [7:0]            out_index,
  output logic [1:0]            out_status
);

  localparam int LW = PW;
  localparam logic [LW-1:0] LINK_END = LW'(POOL_DEPTH);
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  // memories
  logic [KEY_BITS-1:0]   hk_mem [BUCKETS];
  logic [VALUE_BITS-1:0] hv_mem [BUCKETS];
  logic [LW-1:0]         hl_mem [BUCKETS];
  logic [KEY_BITS-1:0]   pk_mem [POOL_DEPTH];
  logic [VALUE_BITS-1:0] pv_mem [POOL_DEPTH];
  logic [LW-1:0]         pl_mem [POOL_DEPTH];
  logic [BUCKETS-1:0]    hvalid_r;
  logic [LW-1:0]         used_r;

  be_state_t             state_r, state_nxt;
  logic [1:0]            func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0]         bkt_r;
  logic                  last_head_r;
  logic [IW-1:0]         last_r;
  logic [LW-1:0]         steps_r;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [LW-1:0]         rd_link_r;
  logic                  found_r;
  logic [7:0]            index_r;
  logic [1:0]            status_r;
  logic                  res_set;
  logic                  res_found;
  logic [VALUE_BITS-1:0] res_val;
  status_t               res_status;
  logic                  do_append;
  logic                  do_head;

  logic                  hit_head, hit_pool;
  assign hit_head = rd_key_r == key_r;
  assign hit_pool = rd_key_r == key_r;

  // walk control
  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    res_set    = 1'b0;
    res_found  = 1'b0;
    res_val    = '0;
    res_status = ST_DONE;
    do_append  = 1'b0;
    do_head    = 1'b0;
    unique case (state_r)
      BE_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_nxt = BE_HEAD_RD;
        end
      end
      BE_HEAD_RD: begin
        state_nxt = BE_RESULT;
        res_set = 1'b1;
        if (func_r == FUNC_CLEAR || func_r == FUNC_NOP) begin
          res_status = ST_DONE;
        end else if (key_r == '0) begin
          res_status = ST_ZERO;
        end else if (!hvalid_r[bkt_r]) begin
          if (func_r == FUNC_INSERT) do_head = 1'b1;
        end else begin
          res_set = 1'b0;
          state_nxt = BE_HEAD_CHK;
        end
      end
      BE_HEAD_CHK, BE_POOL_CHK: begin
        if (state_r == BE_HEAD_CHK ? hit_head : hit_pool) begin
          res_set = 1'b1;
          res_found = 1'b1;
          res_val = rd_val_r;
          res_status = (func_r == FUNC_INSERT) ? ST_PRESENT : ST_DONE;
          state_nxt = BE_RESULT;
        end else if (rd_link_r < used_r && steps_r < LW'(POOL_DEPTH)) begin
          state_nxt = BE_POOL_RD;
        end else begin
          res_set = 1'b1;
          state_nxt = BE_RESULT;
          if (func_r == FUNC_INSERT) begin
            if (used_r >= LW'(POOL_DEPTH)) res_status = ST_FULL;
            else do_append = 1'b1;
          end
        end
      end
      BE_POOL_RD: state_nxt = BE_POOL_CHK;
      BE_RESULT: begin
        if (!out_stall) state_nxt = BE_IDLE;
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BE_IDLE;
    else state_r <= state_nxt;
  end

  // control state: valid bits and pool bump pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
      used_r   <= '0;
    end else if (state_r == BE_HEAD_RD && func_r == FUNC_CLEAR) begin
      hvalid_r <= '0;
      used_r   <= '0;
    end else begin
      if (do_head) hvalid_r[bkt_r] <= 1'b1;
      if (do_append) used_r <= used_r + LW'(1);
    end
  end

  // item capture and walk datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      func_r <= q_func;
      key_r  <= q_key;
      val_r  <= q_value;
      bkt_r  <= q_bucket;
    end
    if (state_r == BE_HEAD_RD) begin
      rd_key_r    <= hk_mem[bkt_r];
      rd_val_r    <= hv_mem[bkt_r];
      rd_link_r   <= hl_mem[bkt_r];
      last_head_r <= 1'b1;
      steps_r     <= '0;
    end else if (state_r == BE_POOL_RD) begin
      rd_key_r    <= pk_mem[rd_link_r[IW-1:0]];
      rd_val_r    <= pv_mem[rd_link_r[IW-1:0]];
      rd_link_r   <= pl_mem[rd_link_r[IW-1:0]];
      last_head_r <= 1'b0;
      last_r      <= rd_link_r[IW-1:0];
      steps_r     <= steps_r + LW'(1);
    end
    if (res_set) begin
      found_r  <= res_found;
      index_r  <= 8'(res_val);
      status_r <= res_status;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (do_head) begin
      hk_mem[bkt_r] <= key_r;
      hv_mem[bkt_r] <= val_r;
      hl_mem[bkt_r] <= LINK_END;
    end
    if (do_append) begin
      pk_mem[used_r[IW-1:0]] <= key_r;
      pv_mem[used_r[IW-1:0]] <= val_r;
      pl_mem[used_r[IW-1:0]] <= LINK_END;
      if (last_head_r) hl_mem[bkt_r] <= used_r;
      else pl_mem[last_r] <= used_r;
    end
  end

  assign out_valid  = state_r == BE_RESULT;
  assign out_found  = found_r;
  assign out_index  = index_r;
  assign out_status = status_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LW'(POOL_DEPTH)) else $error("pool count overrun");
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_DONE || out_status == ST_PRESENT)
    else $error("found with bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index))
    else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BE_IDLE) else $error("pop while busy");

endmodule

[sv/chained_hash_id_to_index_map.sv]
// order: the front end captures an input item and runs a bit-serial modulo divide
//   of the key; the back end reads the bucket head and gives the result for clear,
//   zero key or empty bucket, else compares the head key, then walks overflow nodes
// overlap: the front end stalls input until its item is pushed to the queue; the
//   back end is busy until its result is taken past output stalls; a two-entry queue overlaps them
// reset: synchronous active low; clears head valid bits, pool count, queue,
//   and sets bucket_count to 101
module chained_hash_id_to_index_map import chim_pkg::*; #(
  parameter int BUCKETS    = 128,
  parameter int POOL_DEPTH = 128,
  parameter int KEY_BITS   = 22,
  parameter int VALUE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_bucket_count,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [KEY_BITS-1:0]   in_task_id,
  input  logic [VALUE_BITS-1:0] in_index_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [7:0]            out_index_out,
  output logic [1:0]            out_status
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = 2 + KEY_BITS + VALUE_BITS + BW;

  logic [7:0]            bcount_r;
  logic                  fq_valid, q_full, q_empty, q_pop;
  logic [1:0]            f_func, b_func;
  logic [KEY_BITS-1:0]   f_key, b_key;
  logic [VALUE_BITS-1:0] f_val, b_val;
  logic [BW-1:0]         f_bkt, b_bkt;
  logic                  q_wr;

  // bucket count register
  always_ff @(posedge clk) begin
    if (!rst_n) bcount_r <= 8'd101;
    else if (cfg_we) bcount_r <= cfg_bucket_count;
  end

  chim_front #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .bucket_count(bcount_r),
    .in_valid, .in_stall, .in_func, .in_task_id, .in_index(in_index_in),
    .q_valid(fq_valid), .q_full, .q_func(f_func), .q_key(f_key),
    .q_value(f_val), .q_bucket(f_bkt)
  );

  assign q_wr = fq_valid && !q_full;

  chim_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_data({f_func, f_key, f_val, f_bkt}),
    .full(q_full), .rd_en(q_pop), .empty(q_empty),
    .rd_data({b_func, b_key, b_val, b_bkt})
  );

  chim_back #(.BUCKETS(BUCKETS), .POOL_DEPTH(POOL_DEPTH), .KEY_BITS(KEY_BITS),
              .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_func(b_func), .q_key(b_key),
    .q_value(b_val), .q_bucket(b_bkt),
    .out_valid, .out_stall, .out_found, .out_index(out_index_out), .out_status
  );

endmodule
